>>> rtl/core/odle_pkg.sv
// Shared types, codes and constants of the ordered deque list engine.
package odle_pkg;

  localparam int ODLE_DEPTH    = 16;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_INSERT     = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture item and compare flags
    logic apply;  // perform the list update
    logic scan;   // one rotation step of the min/max walk
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_none;  // nothing to walk after the update
    logic scan_last;  // current walk step is the last one
  } dp_stat_t;

endpackage

>>> rtl/core/odle_if.sv
// Valid/ready channel interfaces for items in and results out.
interface odle_in_if;
  import odle_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, output op, output operand_value, input ready);
  modport sink   (input valid, input op, input operand_value, output ready);
endinterface

interface odle_out_if;
  import odle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] result_value;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] max_value;

  modport source (output valid, output status, output result_value, output entry_count,
                  output min_value, output max_value, input ready);
  modport sink   (input valid, input status, input result_value, input entry_count,
                  input min_value, input max_value, output ready);
endinterface

>>> rtl/core/odle_ctrl.sv
// Sequencing state machine: accept, update, min/max walk, deliver.
module odle_ctrl
  import odle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output cmd_t     cmd,
  input  dp_stat_t dp_stat
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_APPLY = 4'b0010,
    S_SCAN  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_APPLY;
      S_APPLY: state_next = dp_stat.scan_none ? S_OUT : S_SCAN;
      S_SCAN:  if (dp_stat.scan_last) state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.apply = (state == S_APPLY);
  assign cmd.scan  = (state == S_SCAN);

  a_ready_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");
  a_load_apply: assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.apply)
    else $error("load not followed by apply");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
                               (cmd.scan && dp_stat.scan_last) |=> out_valid)
    else $error("walk end did not present result");
endmodule

>>> rtl/core/odle_dp.sv
// Datapath: row of entry cells with parallel compare, shift and rotate.
module odle_dp
  import odle_pkg::*;
#(
  parameter int DEPTH = ODLE_DEPTH
)(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output dp_stat_t                 dp_stat,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic [STATUS_W-1:0]      status,
  output logic signed [DATA_W-1:0] result_value,
  output logic [ENTRY_COUNT_W-1:0] entry_count,
  output logic signed [DATA_W-1:0] min_value,
  output logic signed [DATA_W-1:0] max_value
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] cells [DEPTH];
  logic signed [DATA_W-1:0] prev_val [DEPTH];
  logic signed [DATA_W-1:0] next_val [DEPTH];
  logic [CW-1:0]            count;
  logic [CW-1:0]            left;
  op_t                      op_r;
  logic signed [DATA_W-1:0] x_r;
  logic [DEPTH-1:0]         flags, flags_next;
  logic [DEPTH-1:0]         first, below_at, at_after;
  logic                     pend_dec;
  logic                     scan_first;
  logic                     is_full, is_empty;
  logic                     do_open, do_close;
  status_t                  stat_r;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // Per-cell compare against the incoming operand.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      logic act, at_cnt;
      act    = (CW'(i) < count);
      at_cnt = (CW'(i) == count);
      unique case (op_t'(in_op))
        OP_FIND, OP_REMOVE: flags_next[i] = act && (cells[i] == in_value);
        OP_INSERT:          flags_next[i] = at_cnt
                                            || (act && (i > 0) && (cells[i] >= in_value))
                                            || (act && (i == 0) && (cells[i] > in_value));
        OP_PUSH_BACK:       flags_next[i] = at_cnt;
        OP_PUSH_FRONT,
        OP_POP_FRONT:       flags_next[i] = (i == 0);
        default:            flags_next[i] = 1'b0;
      endcase
    end
  end

  // First set flag and everything from it toward the back.
  assign first    = flags & ~(flags - DEPTH'(1));
  assign below_at = flags ^ (flags - DEPTH'(1));
  assign at_after = ~below_at | first;

  always_comb begin
    do_open  = 1'b0;
    do_close = 1'b0;
    unique case (op_r)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: do_open = !is_full;
      OP_POP_FRONT:                           do_close = !is_empty;
      OP_REMOVE:                              do_close = !is_empty && (flags != '0);
      default: ;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_val[g] = x_r;
    end else begin : g_mid
      assign prev_val[g] = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_val[g] = cells[g];
    end else begin : g_body
      assign next_val[g] = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply && do_open && at_after[g]) begin
        cells[g] <= first[g] ? x_r : prev_val[g];
      end else if (cmd.apply && do_close && at_after[g]) begin
        cells[g] <= next_val[g];
      end else if (cmd.scan && (CW'(g) < count)) begin
        cells[g] <= (CW'(g) == count - CW'(1)) ? cells[0] : next_val[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      if (do_open)       count <= count + CW'(1);
      else if (do_close) count <= count - CW'(1);
    end else if (cmd.scan && pend_dec && (left == CW'(1))) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      x_r   <= in_value;
      flags <= flags_next;
    end
    if (cmd.apply) begin
      result_value <= '0;
      min_value    <= '0;
      max_value    <= '0;
      scan_first   <= 1'b1;
      pend_dec     <= (op_r == OP_POP_BACK) && !is_empty;
      stat_r       <= ST_OK;
      unique case (op_r)
        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: if (is_full) stat_r <= ST_FULL;
        OP_POP_BACK: if (is_empty) stat_r <= ST_EMPTY;
        OP_POP_FRONT: begin
          if (is_empty) stat_r <= ST_EMPTY;
          else          result_value <= cells[0];
        end
        OP_FIND, OP_REMOVE: begin
          if (is_empty)           stat_r <= ST_EMPTY;
          else if (flags == '0)   stat_r <= ST_NOTFOUND;
        end
        default: ;
      endcase
      if (do_open)       left <= count + CW'(1);
      else if (do_close) left <= count - CW'(1);
      else               left <= count;
    end
    if (cmd.scan) begin
      left <= left - CW'(1);
      if (pend_dec && (left == CW'(1))) begin
        result_value <= cells[0];
      end else begin
        scan_first <= 1'b0;
        if (scan_first || (cells[0] < min_value)) min_value <= cells[0];
        if (scan_first || (cells[0] > max_value)) max_value <= cells[0];
      end
    end
  end

  // During apply, the walk length is the count the update leaves behind.
  assign dp_stat.scan_none = (do_open ? 1'b0 : do_close ? (count == CW'(1)) : is_empty);
  assign dp_stat.scan_last = (left == CW'(1));

  assign status      = stat_r;
  assign entry_count = ENTRY_COUNT_W'(count);
endmodule

>>> rtl/core/ordered_deque_list_engine_top.sv
// Top level of the ordered deque list engine.
// Per item: accept, update the entry row, min/max walk over N entries, then result
//   valid; N = entries after the update, or entries before it for a pop back.
// One item is in flight at a time.
// The walk is set by rotating the entry row one position per cycle.
// Reset (rst, synchronous, active high) empties the list; entry contents are
//   not cleared, only the count.
module ordered_deque_list_engine_top
  import odle_pkg::*;
#(
  parameter int DEPTH = ODLE_DEPTH
)(
  input logic        clk,
  input logic        rst,
  odle_in_if.sink    in_ch,
  odle_out_if.source out_ch
);

  cmd_t     cmd;
  dp_stat_t dp_stat;

  // Controller: handshakes and step sequencing.
  odle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .dp_stat   (dp_stat)
  );

  // Datapath: entry cells, compare flags, shift/rotate, min/max.
  odle_dp #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_stat      (dp_stat),
    .in_op        (in_ch.op),
    .in_value     (in_ch.operand_value),
    .status       (out_ch.status),
    .result_value (out_ch.result_value),
    .entry_count  (out_ch.entry_count),
    .min_value    (out_ch.min_value),
    .max_value    (out_ch.max_value)
  );

  a_no_quick_out: assert property (@(posedge clk) disable iff (rst)
                                   (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
    else $error("result valid right after acceptance");
  a_out_to_idle: assert property (@(posedge clk) disable iff (rst)
                                  (out_ch.valid && out_ch.ready) |=> in_ch.ready)
    else $error("not ready after delivering result");
  a_empty_minmax: assert property (@(posedge clk) disable iff (rst)
                                   (out_ch.valid && out_ch.entry_count == '0 && DEPTH < 32)
                                   |-> (out_ch.min_value == '0 && out_ch.max_value == '0))
    else $error("nonzero min/max on empty list");
endmodule

>>> sim/odle_tb_pkg.sv
// Scoreboard class that predicts list results and checks them.
`timescale 1ns / 100ps
package odle_tb_pkg;
  import odle_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] result_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries[$];
    list_result_t pending_results[$];
    int error_count;

    function void clear();
      entries.delete();
      pending_results.delete();
      error_count = 0;
    endfunction

    function void note_item(op_t op, logic signed [DATA_W-1:0] v);
      list_result_t r;
      int pos;
      bit hit;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
          if (entries.size() >= ODLE_DEPTH) begin
            r.status = ST_FULL;
          end else if (op == OP_PUSH_BACK) begin
            entries.push_back(v);
          end else if (op == OP_PUSH_FRONT || entries.size() == 0 || entries[0] > v) begin
            entries.push_front(v);
          end else begin
            pos = 1;
            while (pos < entries.size() && entries[pos] < v) pos++;
            entries.insert(pos, v);
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (entries.size() == 0) r.status = ST_EMPTY;
          else if (op == OP_POP_BACK) r.result_value = entries.pop_back();
          else r.result_value = entries.pop_front();
        end
        OP_FIND, OP_REMOVE: begin
          if (entries.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            hit = 0;
            for (pos = 0; pos < entries.size(); pos++) begin
              if (entries[pos] == v) begin
                hit = 1;
                break;
              end
            end
            if (!hit) r.status = ST_NOTFOUND;
            else if (op == OP_REMOVE) entries.delete(pos);
          end
        end
        default: ;
      endcase
      r.entry_count = ENTRY_COUNT_W'(entries.size());
      if (entries.size() > 0) begin
        r.min_value = entries[0];
        r.max_value = entries[0];
        foreach (entries[i]) begin
          if (entries[i] < r.min_value) r.min_value = entries[i];
          if (entries[i] > r.max_value) r.max_value = entries[i];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void report(string what, longint got, longint want);
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result, count", got.entry_count, -1);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.result_value !== want.result_value)
        report("result_value", got.result_value, want.result_value);
      if (got.entry_count !== want.entry_count)
        report("entry_count", got.entry_count, want.entry_count);
      if (got.min_value !== want.min_value) report("min_value", got.min_value, want.min_value);
      if (got.max_value !== want.max_value) report("max_value", got.max_value, want.max_value);
    endfunction
  endclass
endpackage

>>> sim/tb.sv
// Testbench top: drives list operations and checks every result.
`timescale 1ns / 100ps
module tb;
  import odle_pkg::*;
  import odle_tb_pkg::*;

  logic clk;
  logic rst;
  int   send_idle_pct;   // chance of a gap before each item
  int   recv_stall_pct;  // chance of holding ready low per cycle

  odle_in_if  in_ch();
  odle_out_if out_ch();

  ordered_deque_list_engine_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  list_scoreboard list_sb;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard limit: allows far more time than the items and stalls need.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random ready, check on each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        list_sb.check_result(list_result_t'{out_ch.status, out_ch.result_value,
                                            out_ch.entry_count, out_ch.min_value,
                                            out_ch.max_value});
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Values drawn mostly from a small pool so finds and removes hit often.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: return -$signed(DATA_W'($urandom_range(1, 8)));
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // Send one item; the scoreboard records it at the accepting edge.
  // Valid stays high into the next item unless the sender idles.
  task automatic send_item(op_t op, logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.operand_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    list_sb.note_item(op, v);
  endtask

  initial begin
    int phase;
    int k;
    list_sb = new();
    list_sb.clear();
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_NOP;
    in_ch.operand_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operations on empty, extremes, insert ordering, full list.
    send_item(OP_POP_BACK, 0);
    send_item(OP_POP_FRONT, 0);
    send_item(OP_FIND, 5);
    send_item(OP_REMOVE, 5);
    send_item(OP_NOP, 0);
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 0);
    send_item(OP_FIND, 32'sh7fffffff);
    send_item(OP_FIND, 3);
    send_item(OP_REMOVE, 0);
    send_item(OP_PUSH_FRONT, -1);
    for (k = 0; k < 13; k++) send_item(OP_PUSH_BACK, k);
    send_item(OP_PUSH_BACK, 99);
    send_item(OP_PUSH_FRONT, 99);
    send_item(OP_INSERT, 99);
    send_item(OP_NOP, 0);
    while (list_sb.entries.size() > 2) send_item(OP_POP_FRONT, 0);
    send_item(OP_POP_BACK, 0);
    send_item(OP_POP_BACK, 0);

    // Random phases: none, sender idle, receiver stall, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 21 : 0;
      recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 21 : 0;
      for (k = 0; k < 8; k++) begin
        // Alternate fill-heavy and drain-heavy stretches.
        repeat (20) send_item(op_t'(($urandom_range(2) == 0) ? $urandom_range(7)
                               : (k[0] ? 2 * $urandom_range(1) + 1
                                       : ($urandom_range(1) ? OP_INSERT : 2 * $urandom_range(1)))),
                              pick_value());
        repeat (20) send_item(op_t'($urandom_range(7)), pick_value());
      end
    end
    in_ch.valid <= 1'b0;

    k = 0;
    while (list_sb.pending_results.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (40) @(posedge clk);
    if (list_sb.error_count == 0 && list_sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
